// ----- hdl/stop_and_wait_arq_controller_defines.svh -----
// Assertion macros for the stop-and-wait ARQ controller checker.
// Used by the bound checker only; needs clk and arst_n in scope.
`ifndef STOP_AND_WAIT_ARQ_CONTROLLER_DEFINES_SVH
`define STOP_AND_WAIT_ARQ_CONTROLLER_DEFINES_SVH

// Property that must hold in the same cycle.
`define SAW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define SAW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/sawarq_pkg.sv -----
// Shared types and codes for the stop-and-wait ARQ controller.
// No dependencies.
`timescale 1ns / 1ps

package sawarq_pkg;

	// protocol states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_TX   = 2'd1;
	localparam logic [1:0] ST_ACK  = 2'd2;

	// event codes
	localparam logic [2:0] EV_WORD  = 3'd0;
	localparam logic [2:0] EV_DRCV  = 3'd1;
	localparam logic [2:0] EV_DSENT = 3'd2;
	localparam logic [2:0] EV_ASENT = 3'd3;
	localparam logic [2:0] EV_ARCV  = 3'd4;
	localparam logic [2:0] EV_TOUT  = 3'd5;

	// action codes
	localparam logic [3:0] ACT_SEND_ACK  = 4'd0;
	localparam logic [3:0] ACT_SEND_DATA = 4'd1;
	localparam logic [3:0] ACT_START_TMR = 4'd2;
	localparam logic [3:0] ACT_ACK_OK    = 4'd3;
	localparam logic [3:0] ACT_MISMATCH  = 4'd4;
	localparam logic [3:0] ACT_RESEND    = 4'd5;
	localparam logic [3:0] ACT_GIVE_UP   = 4'd6;
	localparam logic [3:0] ACT_ACK_DONE  = 4'd7;
	localparam logic [3:0] ACT_WARN      = 4'd8;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_PEER_ADDR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIM = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SEQ_MOD   = 2'd2;
	localparam int unsigned CFG_DATA_W = 9;

	// at most this many actions per event
	localparam int unsigned MAX_ACTIONS = 6;
	localparam int unsigned CNT_W = 3;

	typedef struct packed {
		logic load;   // take the accepted event into the pending flags
		logic drain;  // consume one flag and register its action
		logic last;   // the drained action closes the request
	} sawarq_cmd_t;

	typedef struct packed {
		logic can_drain;   // a flag is consumable now
		logic more_after;  // a flag would still be consumable after this drain
	} sawarq_status_t;

endpackage

// ----- hdl/sawarq_ctrl.sv -----
// Sequencer for the stop-and-wait ARQ controller: input/output handshakes
// and drain counting. Depends on sawarq_pkg.
`timescale 1ns / 1ps

module sawarq_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	output logic                       out_valid,
	input  logic                       out_stall,
	input  sawarq_pkg::sawarq_status_t status,
	output sawarq_pkg::sawarq_cmd_t    cmd
);

	localparam logic C_IDLE  = 1'b0;
	localparam logic C_DRAIN = 1'b1;

	logic                          state_q;
	logic                          state_d;
	logic [sawarq_pkg::CNT_W-1:0]  cnt_q;
	logic                          out_valid_q;
	logic                          slot_free;
	logic                          last_act;

	assign slot_free = !out_valid_q || !out_stall;
	assign last_act  = (cnt_q == sawarq_pkg::CNT_W'(sawarq_pkg::MAX_ACTIONS - 1))
		|| !status.more_after;

	assign in_stall  = (state_q != C_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.load  = (state_q == C_IDLE) && in_valid;
		cmd.drain = (state_q == C_DRAIN) && slot_free && status.can_drain;
		cmd.last  = last_act;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			C_IDLE: begin
				if (in_valid)
					state_d = C_DRAIN;
			end
			C_DRAIN: begin
				if (!status.can_drain)
					state_d = C_IDLE;
				else if (cmd.drain && last_act)
					state_d = C_IDLE;
			end
			default: state_d = C_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= C_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load)
				cnt_q <= '0;
			else if (cmd.drain)
				cnt_q <= cnt_q + 1'b1;
			if (cmd.drain)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- hdl/sawarq_dp.sv -----
// Datapath of the stop-and-wait ARQ controller: config registers, protocol
// state, pending flags, drain priority and the output register. Uses sawarq_pkg.
`timescale 1ns / 1ps

module sawarq_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [sawarq_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sawarq_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [2:0]                             func,
	input  logic [7:0]                             peer_source,
	input  logic [7:0]                             peer_seq,
	input  sawarq_pkg::sawarq_cmd_t                cmd,
	output sawarq_pkg::sawarq_status_t             status,
	output logic [3:0]                             action,
	output logic [7:0]                             frame_seq,
	output logic [7:0]                             frame_dest,
	output logic [2:0]                             ignored_event,
	output logic [1:0]                             state_after,
	output logic                                   last
);

	// configuration
	logic [7:0] peer_addr_q;
	logic [7:0] retry_lim_q;
	logic [8:0] seq_mod_q;

	// protocol state
	logic [1:0] pstate_q;
	logic [5:0] pend_q;
	logic [7:0] next_seq_q;
	logic [7:0] sent_seq_q;
	logic [7:0] retry_q;
	logic       timer_q;
	logic [7:0] held_src_q;
	logic [7:0] held_seq_q;

	// drain results
	logic [1:0] d_pstate;
	logic [5:0] d_pend;
	logic [7:0] d_next_seq;
	logic [7:0] d_sent_seq;
	logic [7:0] d_retry;
	logic       d_timer;
	logic [3:0] d_act;
	logic [7:0] d_seq;
	logic [7:0] d_dest;
	logic [2:0] d_ign;
	logic       d_fire;
	logic [8:0] seq_inc;
	logic [7:0] retry_inc;

	// output register
	logic [3:0] act_q;
	logic [7:0] fseq_q;
	logic [7:0] fdest_q;
	logic [2:0] ign_q;
	logic [1:0] st_after_q;
	logic       last_q;

	function automatic logic consumable(input logic [1:0] st, input logic [5:0] p);
		logic r;
		r = 1'b0;
		unique case (st)
			sawarq_pkg::ST_IDLE: r = |p;
			sawarq_pkg::ST_TX:   r = p[sawarq_pkg::EV_ASENT] | p[sawarq_pkg::EV_DSENT];
			sawarq_pkg::ST_ACK:  r = |p[5:1];
			default:             r = 1'b0;
		endcase
		return r;
	endfunction

	assign seq_inc   = {1'b0, next_seq_q} + 9'd1;
	assign retry_inc = retry_q + 8'd1;

	always_comb begin
		d_pstate   = pstate_q;
		d_pend     = pend_q;
		d_next_seq = next_seq_q;
		d_sent_seq = sent_seq_q;
		d_retry    = retry_q;
		d_timer    = timer_q;
		d_act      = sawarq_pkg::ACT_WARN;
		d_seq      = 8'd0;
		d_dest     = 8'd0;
		d_ign      = 3'd0;
		d_fire     = 1'b1;
		unique case (pstate_q)
			sawarq_pkg::ST_IDLE: begin
				if (pend_q[sawarq_pkg::EV_DRCV]) begin
					d_pend[sawarq_pkg::EV_DRCV] = 1'b0;
					d_pstate = sawarq_pkg::ST_TX;
					d_act    = sawarq_pkg::ACT_SEND_ACK;
					d_seq    = held_seq_q;
					d_dest   = held_src_q;
				end else if (pend_q[sawarq_pkg::EV_WORD]) begin
					d_pend[sawarq_pkg::EV_WORD] = 1'b0;
					d_sent_seq = next_seq_q;
					// wrap; modulus 0 behaves as 256
					if (seq_mod_q != 9'd0 && seq_inc >= seq_mod_q)
						d_next_seq = 8'd0;
					else
						d_next_seq = seq_inc[7:0];
					d_retry  = 8'd0;
					d_pstate = sawarq_pkg::ST_TX;
					d_act    = sawarq_pkg::ACT_SEND_DATA;
					d_seq    = next_seq_q;
					d_dest   = peer_addr_q;
				end else if (pend_q[sawarq_pkg::EV_DSENT]) begin
					d_pend[sawarq_pkg::EV_DSENT] = 1'b0;
					d_ign = sawarq_pkg::EV_DSENT;
				end else if (pend_q[sawarq_pkg::EV_ASENT]) begin
					d_pend[sawarq_pkg::EV_ASENT] = 1'b0;
					d_ign = sawarq_pkg::EV_ASENT;
				end else if (pend_q[sawarq_pkg::EV_ARCV]) begin
					d_pend[sawarq_pkg::EV_ARCV] = 1'b0;
					d_ign = sawarq_pkg::EV_ARCV;
				end else if (pend_q[sawarq_pkg::EV_TOUT]) begin
					d_pend[sawarq_pkg::EV_TOUT] = 1'b0;
					d_ign = sawarq_pkg::EV_TOUT;
				end else begin
					d_fire = 1'b0;
				end
			end
			sawarq_pkg::ST_TX: begin
				if (pend_q[sawarq_pkg::EV_ASENT]) begin
					d_pend[sawarq_pkg::EV_ASENT] = 1'b0;
					d_pstate = (timer_q || pend_q[sawarq_pkg::EV_TOUT]) ?
						sawarq_pkg::ST_ACK : sawarq_pkg::ST_IDLE;
					d_act = sawarq_pkg::ACT_ACK_DONE;
				end else if (pend_q[sawarq_pkg::EV_DSENT]) begin
					d_pend[sawarq_pkg::EV_DSENT] = 1'b0;
					d_pstate = sawarq_pkg::ST_ACK;
					d_timer  = 1'b1;
					d_act    = sawarq_pkg::ACT_START_TMR;
					d_seq    = sent_seq_q;
					d_dest   = peer_addr_q;
				end else begin
					d_fire = 1'b0;
				end
			end
			sawarq_pkg::ST_ACK: begin
				if (pend_q[sawarq_pkg::EV_ARCV]) begin
					d_pend[sawarq_pkg::EV_ARCV] = 1'b0;
					d_seq  = held_seq_q;
					d_dest = held_src_q;
					if (held_seq_q == sent_seq_q) begin
						d_timer  = 1'b0;
						d_pstate = sawarq_pkg::ST_IDLE;
						d_act    = sawarq_pkg::ACT_ACK_OK;
					end else begin
						d_act = sawarq_pkg::ACT_MISMATCH;
					end
				end else if (pend_q[sawarq_pkg::EV_TOUT]) begin
					d_pend[sawarq_pkg::EV_TOUT] = 1'b0;
					d_retry = retry_inc;
					d_seq   = sent_seq_q;
					d_dest  = peer_addr_q;
					if (retry_inc >= retry_lim_q) begin
						d_pstate = sawarq_pkg::ST_IDLE;
						d_pend[sawarq_pkg::EV_DSENT] = 1'b0;
						d_act = sawarq_pkg::ACT_GIVE_UP;
					end else begin
						d_pstate = sawarq_pkg::ST_TX;
						d_act    = sawarq_pkg::ACT_RESEND;
					end
				end else if (pend_q[sawarq_pkg::EV_DRCV]) begin
					d_pend[sawarq_pkg::EV_DRCV] = 1'b0;
					d_pstate = sawarq_pkg::ST_TX;
					d_act    = sawarq_pkg::ACT_SEND_ACK;
					d_seq    = held_seq_q;
					d_dest   = held_src_q;
				end else if (pend_q[sawarq_pkg::EV_DSENT]) begin
					d_pend[sawarq_pkg::EV_DSENT] = 1'b0;
					d_ign = sawarq_pkg::EV_DSENT;
				end else if (pend_q[sawarq_pkg::EV_ASENT]) begin
					d_pend[sawarq_pkg::EV_ASENT] = 1'b0;
					d_ign = sawarq_pkg::EV_ASENT;
				end else begin
					d_fire = 1'b0;
				end
			end
			default: d_fire = 1'b0;
		endcase
	end

	always_comb begin
		status.can_drain  = d_fire;
		status.more_after = consumable(d_pstate, d_pend);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peer_addr_q <= 8'd0;
			retry_lim_q <= 8'd4;
			seq_mod_q   <= 9'd256;
			pstate_q    <= sawarq_pkg::ST_IDLE;
			pend_q      <= '0;
			next_seq_q  <= 8'd0;
			sent_seq_q  <= 8'd0;
			retry_q     <= 8'd0;
			timer_q     <= 1'b0;
			held_src_q  <= 8'd0;
			held_seq_q  <= 8'd0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					sawarq_pkg::CFG_PEER_ADDR: peer_addr_q <= cfg_data[7:0];
					sawarq_pkg::CFG_RETRY_LIM: retry_lim_q <= cfg_data[7:0];
					sawarq_pkg::CFG_SEQ_MOD:   seq_mod_q   <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.load) begin
				unique case (func) inside
					sawarq_pkg::EV_WORD, sawarq_pkg::EV_DSENT, sawarq_pkg::EV_ASENT:
						pend_q[func] <= 1'b1;
					sawarq_pkg::EV_DRCV, sawarq_pkg::EV_ARCV: begin
						pend_q[func] <= 1'b1;
						held_src_q   <= peer_source;
						held_seq_q   <= peer_seq;
					end
					sawarq_pkg::EV_TOUT: begin
						pend_q[func] <= 1'b1;
						timer_q      <= 1'b0;
					end
					default: ;  // unknown events leave no trace
				endcase
			end else if (cmd.drain) begin
				pstate_q   <= d_pstate;
				pend_q     <= d_pend;
				next_seq_q <= d_next_seq;
				sent_seq_q <= d_sent_seq;
				retry_q    <= d_retry;
				timer_q    <= d_timer;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.drain) begin
			act_q      <= d_act;
			fseq_q     <= d_seq;
			fdest_q    <= d_dest;
			ign_q      <= d_ign;
			st_after_q <= d_pstate;
			last_q     <= cmd.last;
		end
	end

	assign action        = act_q;
	assign frame_seq     = fseq_q;
	assign frame_dest    = fdest_q;
	assign ignored_event = ign_q;
	assign state_after   = st_after_q;
	assign last          = last_q;

endmodule

// ----- hdl/stop_and_wait_arq_controller.sv -----
// Top level of the stop-and-wait ARQ controller.
// Instantiates sawarq_ctrl and sawarq_dp; uses sawarq_pkg.
`timescale 1ns / 1ps

// Usage
//  Input channel (in_valid/in_stall) carries one event: func, peer_source,
//  peer_seq. Output channel (out_valid/out_stall) carries one action per
//  request, with last set on the final action caused by the event.
//  An event sets its pending flag; the block then drains flags one per cycle
//  while the output is not stalled, in the per-state priority, giving 0 to 6
//  actions. The event is first loaded into the pending flags; each drain then
//  registers one action in the output register.
//  Further events are stalled until the final action is registered; the
//  next event may be taken while that action still waits at the output.
//  A stalled receiver holds the output register and pauses the drain.
//  Configuration (cfg_we, cfg_index, cfg_data) must be written by the user
//  only while idle; the block itself does not enforce this.
//  Reset clears protocol state, pending flags and counters, and loads
//  the default configuration (peer 0, retry limit 4, modulus 256).

module stop_and_wait_arq_controller (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [sawarq_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sawarq_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [2:0]                         func,
	input  logic [7:0]                         peer_source,
	input  logic [7:0]                         peer_seq,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [3:0]                         action,
	output logic [7:0]                         frame_seq,
	output logic [7:0]                         frame_dest,
	output logic [2:0]                         ignored_event,
	output logic [1:0]                         state_after,
	output logic                               last
);

	sawarq_pkg::sawarq_cmd_t    cmd;
	sawarq_pkg::sawarq_status_t status;

	sawarq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	sawarq_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.func          (func),
		.peer_source   (peer_source),
		.peer_seq      (peer_seq),
		.cmd           (cmd),
		.status        (status),
		.action        (action),
		.frame_seq     (frame_seq),
		.frame_dest    (frame_dest),
		.ignored_event (ignored_event),
		.state_after   (state_after),
		.last          (last)
	);

endmodule

// ----- hdl/sawarq_checker.sv -----
// Port-level checker for the stop-and-wait ARQ controller, bound to the top.
// Uses sawarq_pkg and stop_and_wait_arq_controller_defines.svh.
`timescale 1ns / 1ps
`include "stop_and_wait_arq_controller_defines.svh"

module sawarq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [3:0] action,
	input logic [7:0] frame_seq,
	input logic [7:0] frame_dest,
	input logic [2:0] ignored_event,
	input logic [1:0] state_after
);

	`SAW_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "output request dropped while stalled")
	`SAW_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(action) && $stable(frame_seq), "stalled action changed")
	`SAW_ASSERT(a_ign_only_warn, !out_valid || action == sawarq_pkg::ACT_WARN || ignored_event == 3'd0, "ignored_event set on a non-warning")
	`SAW_ASSERT(a_ackdone_zero, !out_valid || action != sawarq_pkg::ACT_ACK_DONE || (frame_seq == 8'd0 && frame_dest == 8'd0), "ack done carries frame fields")
	`SAW_ASSERT(a_send_in_tx, !out_valid || (action != sawarq_pkg::ACT_SEND_DATA && action != sawarq_pkg::ACT_RESEND) || state_after == sawarq_pkg::ST_TX, "send without entering tx")

endmodule

bind stop_and_wait_arq_controller sawarq_checker u_sawarq_checker (.*);
